// ----- rtl/core/quoted_printable_decoder_assert.svh -----
// Assertion macros for the quoted-printable decoder
`ifndef QUOTED_PRINTABLE_DECODER_ASSERT_SVH
`define QUOTED_PRINTABLE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define QPD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("qpd assertion failed");
`define QPD_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("qpd forbidden condition seen");
`else
`define QPD_ASSERT(label, clk, rst_n, prop)
`define QPD_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- rtl/core/qpd_pkg.sv -----
package qpd_pkg;

	localparam logic [7:0] CH_EQUALS     = 8'h3D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_LF         = 8'h0A;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FIRST,
		PH_SECOND
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] nibble;
		logic       is_hex;
		logic       is_cr;
	} qpd_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       bad_escape;
		logic       out_last;
	} qpd_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	localparam qpd_state_t STATE_IDLE = '{phase: PH_IDLE, nibble: 4'd0,
		is_hex: 1'b0, is_cr: 1'b0};

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.ok  = 1'b1;
			h.val = c[3:0] + 4'd9;
		end
		return h;
	endfunction

endpackage

// ----- rtl/core/quoted_printable_decoder.sv -----
// Quoted-printable decoder, one encoded character per item.
// Input channel s_axis: tdata[7:0] is the character, tlast marks the last
// character of a text. Output channel m_axis: tdata[7:0] is the decoded
// byte, tuser[0] says a byte is present, tuser[1] flags a bad escape,
// tlast marks the result caused by the last input character.
// cfg_we/cfg_wdata write the underscore-to-space mode bit; write it only
// while the block is idle.
// Each character is decoded in the cycle it is accepted; its result is
// registered in the output or skid stage. One character is taken every
// cycle while s_axis_tready is high; an '=' and the character after it
// give no result until the escape completes, and a soft line break none.
// The output register is backed by a one-entry skid stage, so an input
// is still taken in the first cycle the receiver stalls; s_axis_tready
// drops only while the skid stage holds a result.
// Reset clears the escape state, the mode bit and both output stages.
`include "quoted_printable_decoder_assert.svh"

module quoted_printable_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_char
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] has_byte, [1] bad_escape
	output logic       m_axis_tlast
);
	import qpd_pkg::*;

	logic        mode_q;
	qpd_state_t  state_q;
	qpd_state_t  state_nxt;
	qpd_result_t res;
	logic        emit;
	qpd_result_t out_q;
	logic        out_valid_q;
	qpd_result_t skid_q;
	logic        skid_valid_q;
	logic        accept;
	logic        push;
	logic        pop;

	qpd_step u_step (
		.in_char             (s_axis_tdata),
		.in_last             (s_axis_tlast),
		.underscore_to_space (mode_q),
		.cur                 (state_q),
		.nxt                 (state_nxt),
		.res                 (res),
		.emit                (emit)
	);

	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = accept && emit;
	assign pop           = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_q.out_byte;
	assign m_axis_tuser[0] = out_q.has_byte;
	assign m_axis_tuser[1] = out_q.bad_escape;
	assign m_axis_tlast    = out_q.out_last;

	`QPD_ASSERT(a_skid_implies_out, clk, arst_n, skid_valid_q |-> out_valid_q)
	`QPD_ASSERT(a_last_gives_result, clk, arst_n, (accept && s_axis_tlast) |=> out_valid_q)
	`QPD_ASSERT(a_last_clears_state, clk, arst_n, (accept && s_axis_tlast) |=> (state_q == STATE_IDLE))
	`QPD_ASSERT(a_skid_only_on_stall, clk, arst_n, $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
	`QPD_NEVER(a_no_gap_byte_flag, clk, arst_n, out_valid_q && out_q.has_byte && out_q.bad_escape)

endmodule

// ----- rtl/core/qpd_step.sv -----
module qpd_step (
	input  logic [7:0]          in_char,
	input  logic                in_last,
	input  logic                underscore_to_space,
	input  qpd_pkg::qpd_state_t cur,
	output qpd_pkg::qpd_state_t nxt,
	output qpd_pkg::qpd_result_t res,
	output logic                emit
);
	import qpd_pkg::*;

	hex_t h;

	assign h = hex_decode(in_char);

	always_comb begin
		nxt          = cur;
		res          = '0;
		res.out_last = in_last;
		emit         = 1'b0;
		unique case (cur.phase)
			PH_FIRST: begin
				nxt.phase  = PH_SECOND;
				nxt.is_hex = h.ok;
				nxt.nibble = h.val;
				nxt.is_cr  = (in_char == CH_CR);
				if (in_last) begin
					if (h.ok) begin
						res.has_byte = 1'b1;
						res.out_byte = {4'd0, h.val};
					end else begin
						res.bad_escape = 1'b1;
					end
				end
			end
			PH_SECOND: begin
				nxt.phase = PH_IDLE;
				if (cur.is_cr && in_char == CH_LF) begin
					emit = 1'b0;
				end else if (cur.is_hex) begin
					emit         = 1'b1;
					res.has_byte = 1'b1;
					res.out_byte = h.ok ? {cur.nibble, h.val} : {4'd0, cur.nibble};
				end else begin
					emit           = 1'b1;
					res.bad_escape = 1'b1;
				end
			end
			default: begin
				if (in_char == CH_EQUALS) begin
					nxt.phase      = PH_FIRST;
					res.bad_escape = in_last;
				end else if (in_char == CH_UNDERSCORE && underscore_to_space) begin
					emit         = 1'b1;
					res.has_byte = 1'b1;
					res.out_byte = CH_SPACE;
				end else begin
					emit         = 1'b1;
					res.has_byte = 1'b1;
					res.out_byte = in_char;
				end
			end
		endcase
		if (in_last) begin
			emit = 1'b1;
			nxt  = STATE_IDLE;
		end
	end

endmodule
